// ===== rtl/mp2d_pkg.sv =====
// Shared constants, types and lookup tables of the max pooling block.
package mp2d_pkg;

  // Window geometry and line store size.
  localparam int POOL        = 2;
  localparam int STRIDE      = 2;
  localparam int MAX_WIDTH   = 32;
  localparam int WIDTH_LIMIT = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;
  localparam int HEIGHT_LIMIT = 32;
  localparam int PLANE_LIMIT = 256;

  localparam int STORE_DEPTH = POOL * MAX_WIDTH;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int WIN_N       = POOL * POOL;

  // Field widths.
  localparam int COORD_W    = 5;
  localparam int PLANE_W    = 8;
  localparam int VAL_W      = 16;
  localparam int RES_W      = 15;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - (RES_W + 2 * COORD_W + PLANE_W);

  // Configuration register map.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [5:0] FRAME_WIDTH_RST   = 6'd24;
  localparam logic [5:0] FRAME_HEIGHT_RST  = 6'd24;
  localparam logic [8:0] CHANNEL_COUNT_RST = 9'd64;

  // Lookup tables indexed by a coordinate.
  localparam int TBL_N = 1 << COORD_W;
  typedef logic [COORD_W-1:0] coord_tbl_t [TBL_N];

  function automatic coord_tbl_t stride_div_tbl();
    coord_tbl_t t;
    for (int i = 0; i < TBL_N; i++) t[i] = COORD_W'(i / STRIDE);
    return t;
  endfunction

  function automatic coord_tbl_t stride_mod_tbl();
    coord_tbl_t t;
    for (int i = 0; i < TBL_N; i++) t[i] = COORD_W'(i % STRIDE);
    return t;
  endfunction

  function automatic coord_tbl_t pool_mod_tbl();
    coord_tbl_t t;
    for (int i = 0; i < TBL_N; i++) t[i] = COORD_W'(i % POOL);
    return t;
  endfunction

  localparam coord_tbl_t STRIDE_DIV = stride_div_tbl();
  localparam coord_tbl_t STRIDE_MOD = stride_mod_tbl();
  localparam coord_tbl_t POOL_MOD   = pool_mod_tbl();

  // Position of the pixel presented at the input, with its window candidates.
  // Bit ky*POOL+kx of win_mask marks the window starting ky rows and kx
  // columns after the earliest possible start that closes on this pixel.
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PLANE_W-1:0] plane;
    logic [WIN_N-1:0]   win_mask;
  } pos_info_t;

  // One pooled result.
  typedef struct packed {
    logic               last;
    logic [PLANE_W-1:0] chan;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [RES_W-1:0]   value;
  } result_t;

endpackage

// ===== rtl/mp2d_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module mp2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/mp2d_pos.sv =====
// Configuration registers, pixel position counters and window candidate mask.
module mp2d_pos import mp2d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pix_accept,
  output pos_info_t             pos_info
);

  logic [5:0]         frame_width_r, frame_width_nxt;
  logic [5:0]         frame_height_r, frame_height_nxt;
  logic [8:0]         channel_count_r, channel_count_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;

  logic [5:0]         eff_w;
  logic [5:0]         eff_h;
  logic [8:0]         eff_cc;
  logic               cfg_hit;
  logic               row_is_last;
  logic               col_is_last;
  logic [POOL-1:0]    row_ok;
  logic [POOL-1:0]    col_ok;
  logic [COORD_W:0]   row_sum [POOL];
  logic [COORD_W:0]   col_sum [POOL];
  logic [COORD_W-1:0] row_start [POOL];
  logic [COORD_W-1:0] col_start [POOL];

  assign cfg_ready = 1'b1;

  // Registers clamped to their usable range.
  always_comb begin
    if (frame_width_r == 6'd0) eff_w = 6'd1;
    else if (frame_width_r > 6'(WIDTH_LIMIT)) eff_w = 6'(WIDTH_LIMIT);
    else eff_w = frame_width_r;

    if (frame_height_r == 6'd0) eff_h = 6'd1;
    else if (frame_height_r > 6'(HEIGHT_LIMIT)) eff_h = 6'(HEIGHT_LIMIT);
    else eff_h = frame_height_r;

    if (channel_count_r == 9'd0) eff_cc = 9'd1;
    else if (channel_count_r > 9'(PLANE_LIMIT)) eff_cc = 9'(PLANE_LIMIT);
    else eff_cc = channel_count_r;
  end

  assign row_is_last = ({1'b0, row_r} == (eff_h - 6'd1));
  assign col_is_last = ({1'b0, col_r} == (eff_w - 6'd1));

  // A window closes on this pixel when its start is on the stride grid and
  // either it is a full window or it is cut short by the plane edge.
  always_comb begin
    for (int k = 0; k < POOL; k++) begin
      row_sum[k]   = {1'b0, row_r} + (COORD_W+1)'(k);
      col_sum[k]   = {1'b0, col_r} + (COORD_W+1)'(k);
      row_start[k] = COORD_W'(row_sum[k] - (COORD_W+1)'(POOL - 1));
      col_start[k] = COORD_W'(col_sum[k] - (COORD_W+1)'(POOL - 1));
      row_ok[k] = (row_sum[k] >= (COORD_W+1)'(POOL - 1)) &&
                  ((k == 0) || row_is_last) &&
                  (STRIDE_MOD[row_start[k]] == '0);
      col_ok[k] = (col_sum[k] >= (COORD_W+1)'(POOL - 1)) &&
                  ((k == 0) || col_is_last) &&
                  (STRIDE_MOD[col_start[k]] == '0);
    end
  end

  always_comb begin
    pos_info.row   = row_r;
    pos_info.col   = col_r;
    pos_info.plane = plane_r;
    for (int ky = 0; ky < POOL; ky++) begin
      for (int kx = 0; kx < POOL; kx++) begin
        pos_info.win_mask[ky*POOL + kx] = row_ok[ky] & col_ok[kx];
      end
    end
  end

  // Register writes and raster position advance; a write to any of the three registers restarts the frame.
  always_comb begin
    frame_width_nxt   = frame_width_r;
    frame_height_nxt  = frame_height_r;
    channel_count_nxt = channel_count_r;
    col_nxt           = col_r;
    row_nxt           = row_r;
    plane_nxt         = plane_r;
    cfg_hit           = 1'b0;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          frame_width_nxt = cfg_data[5:0];
          cfg_hit = 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          frame_height_nxt = cfg_data[5:0];
          cfg_hit = 1'b1;
        end
        REG_CHANNEL_COUNT: begin
          channel_count_nxt = cfg_data;
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end

    if (cfg_hit) begin
      col_nxt   = '0;
      row_nxt   = '0;
      plane_nxt = '0;
    end else if (pix_accept) begin
      if (col_is_last) begin
        col_nxt = '0;
        if (row_is_last) begin
          row_nxt = '0;
          if (({1'b0, plane_r} + 9'd1) >= eff_cc) plane_nxt = '0;
          else plane_nxt = plane_r + PLANE_W'(1);
        end else begin
          row_nxt = row_r + COORD_W'(1);
        end
      end else begin
        col_nxt = col_r + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= FRAME_WIDTH_RST;
      frame_height_r  <= FRAME_HEIGHT_RST;
      channel_count_r <= CHANNEL_COUNT_RST;
      col_r           <= '0;
      row_r           <= '0;
      plane_r         <= '0;
    end else begin
      frame_width_r   <= frame_width_nxt;
      frame_height_r  <= frame_height_nxt;
      channel_count_r <= channel_count_nxt;
      col_r           <= col_nxt;
      row_r           <= row_nxt;
      plane_r         <= plane_nxt;
    end
  end

  // The position never lies outside the clamped plane.
  a_col_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < eff_w)
    else $error("column counter beyond frame width");

  a_row_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, row_r} < eff_h)
    else $error("row counter beyond frame height");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (col_r == '0 && row_r == '0 && plane_r == '0))
    else $error("register write did not restart the frame");

endmodule

// ===== rtl/mp2d_seq.sv =====
// Window sequencer: line store writes, window reads, running maximum, output register.
module mp2d_seq import mp2d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [VAL_W-1:0]     pixel_value,
  input  pos_info_t            pos_info,
  output logic                 out_valid,
  input  logic                 out_ready,
  output result_t              result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;
  logic [WIN_N-1:0]   mask_r, mask_nxt;
  logic [COORD_W-1:0] y0_r, y0_nxt;
  logic [COORD_W-1:0] x0_r, x0_nxt;
  logic [COORD_W-1:0] yi_r, yi_nxt;
  logic [COORD_W-1:0] xi_r, xi_nxt;
  logic [RES_W-1:0]   best_r, best_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               last_r, last_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            result_r, result_nxt;

  logic               pix_accept;
  logic               out_load;
  logic               found;
  logic [COORD_W-1:0] sel_ky;
  logic [COORD_W-1:0] sel_kx;
  logic [WIN_N-1:0]   sel_bit;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [VAL_W-1:0]   rd_data;

  assign in_ready   = (state_r == S_IDLE);
  assign pix_accept = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign result     = result_r;

  // Line store: one row slot per window row, one entry per column.
  mp2d_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (pixel_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign wr_en   = pix_accept;
  assign wr_addr = ADDR_W'(POOL_MOD[pos_info.row]) * ADDR_W'(MAX_WIDTH) +
                   ADDR_W'(pos_info.col);
  assign rd_en   = (state_r == S_READ);
  assign rd_addr = ADDR_W'(POOL_MOD[yi_r]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xi_r);

  // Lowest pending window in row-major candidate order.
  always_comb begin
    found   = 1'b0;
    sel_ky  = '0;
    sel_kx  = '0;
    sel_bit = '0;
    for (int ky = 0; ky < POOL; ky++) begin
      for (int kx = 0; kx < POOL; kx++) begin
        if (!found && mask_r[ky*POOL + kx]) begin
          found   = 1'b1;
          sel_ky  = COORD_W'(ky);
          sel_kx  = COORD_W'(kx);
          sel_bit = WIN_N'(1) << (ky*POOL + kx);
        end
      end
    end
  end

  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    plane_nxt     = plane_r;
    mask_nxt      = mask_r;
    y0_nxt        = y0_r;
    x0_nxt        = x0_r;
    yi_nxt        = yi_r;
    xi_nxt        = xi_r;
    best_nxt      = best_r;
    last_nxt      = last_r;
    rd_pend_nxt   = (state_r == S_READ);
    out_valid_nxt = out_valid_r;
    result_nxt    = result_r;

    // Running maximum over data returned by the line store; it starts at zero.
    if (rd_pend_r && !rd_data[VAL_W-1] && (rd_data[RES_W-1:0] > best_r)) begin
      best_nxt = rd_data[RES_W-1:0];
    end

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (pix_accept) begin
          row_nxt   = pos_info.row;
          col_nxt   = pos_info.col;
          plane_nxt = pos_info.plane;
          mask_nxt  = pos_info.win_mask;
          if (pos_info.win_mask != '0) state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        y0_nxt    = row_r + sel_ky - COORD_W'(POOL - 1);
        x0_nxt    = col_r + sel_kx - COORD_W'(POOL - 1);
        yi_nxt    = row_r + sel_ky - COORD_W'(POOL - 1);
        xi_nxt    = col_r + sel_kx - COORD_W'(POOL - 1);
        best_nxt  = '0;
        mask_nxt  = mask_r & ~sel_bit;
        last_nxt  = ((mask_r & ~sel_bit) == '0);
        state_nxt = found ? S_READ : S_IDLE;
      end
      S_READ: begin
        if (xi_r == col_r) begin
          xi_nxt = x0_r;
          if (yi_r == row_r) state_nxt = S_WAIT;
          else yi_nxt = yi_r + COORD_W'(1);
        end else begin
          xi_nxt = xi_r + COORD_W'(1);
        end
      end
      S_WAIT: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt    = 1'b1;
          result_nxt.value = best_r;
          result_nxt.col   = STRIDE_DIV[x0_r];
          result_nxt.row   = STRIDE_DIV[y0_r];
          result_nxt.chan  = plane_r;
          result_nxt.last  = last_r;
          state_nxt        = (mask_r == '0) ? S_IDLE : S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mask_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    plane_r  <= plane_nxt;
    y0_r     <= y0_nxt;
    x0_r     <= x0_nxt;
    yi_r     <= yi_nxt;
    xi_r     <= xi_nxt;
    best_r   <= best_nxt;
    last_r   <= last_nxt;
    result_r <= result_nxt;
  end

  // No window is left pending once the sequencer is back at rest.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> mask_r == '0)
    else $error("idle with windows still pending");

  // Read addresses stay inside the current window.
  a_read_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> (yi_r >= y0_r && yi_r <= row_r &&
                           xi_r >= x0_r && xi_r <= col_r))
    else $error("line store read outside the window");

  // Returned read data always follows a read cycle.
  a_read_return: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(state_r) == S_READ)
    else $error("read data flagged without a read");

  // The final result of a pixel hands control back to the input.
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_r) |=> state_r == S_IDLE)
    else $error("last result did not end the pixel");

endmodule

// ===== rtl/max_pool_2d_stream.sv =====
// Top level of the streaming 2-D max pooling block.
// A pixel that closes no window is done once accepted; no new pixel is accepted
// while its windows are pending, each read once per in-bounds pixel through the
// single read port of the line store, then passed through the wait and emit states.
// The emit state registers the result onto out_tvalid when the output is free.
// Reset (rst_n low, synchronous) clears counters and output, loads 24/24/64 into
// the registers, and leaves the line store contents undefined (no clearing pass).
module max_pool_2d_stream import mp2d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] pixel_value
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [14:0] pooled_value, [19:15] out_col,
                                            // [24:20] out_row, [32:25] out_channel,
                                            // [39:33] zero
  output logic                  out_tlast,  // last_of_run
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pos_info_t pos_info;
  result_t   result;
  logic      pix_accept;

  assign pix_accept = in_tvalid && in_tready;

  // Registers and raster position.
  mp2d_pos u_pos (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_accept (pix_accept),
    .pos_info   (pos_info)
  );

  // Line store and window sequencer.
  mp2d_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .pixel_value (in_tdata[VAL_W-1:0]),
    .pos_info    (pos_info),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .result      (result)
  );

  // Result packing, first field in the lowest bits.
  assign out_tdata = {{OUT_PAD_W{1'b0}}, result.chan, result.row, result.col, result.value};
  assign out_tlast = result.last;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the streaming 2-D max pooling block.
module tb_top;
  import mp2d_pkg::*;

  // Index with no register behind it; a write there must leave the frame running.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  // Wait long enough for the four 2x2 windows of one pixel, plus margin.
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  typedef enum {RX_STEADY, RX_CHOPPY, RX_STARVED} rx_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  max_pool_2d_stream dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Predictor copy of the line store, the frame position and the registers.
  logic signed [VAL_W-1:0] line_buf [STORE_DEPTH];
  int       frame_w;
  int       frame_h;
  int       plane_total;
  int       next_col;
  int       next_row;
  int       next_plane;
  result_t  pooled_q [$];

  int       error_count;
  int       pixels_sent;
  int       results_seen;
  int       reg_writes;
  int       burst_left;
  rx_mode_t rx_mode;
  int       rx_left;
  result_t  got;
  result_t  want;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, well above the slowest correct run.
  initial begin
    #400000;
    $display("Timeout: %0d pooled results still outstanding", pooled_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int clamp_int(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Last in-bounds coordinate of a window starting at s within an extent of n.
  function automatic int span_end(input int s, input int n);
    int e;
    e = s + POOL;
    if (e > n) e = n;
    return e - 1;
  endfunction

  // Register writes update the predictor and restart the frame.
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FRAME_WIDTH:   frame_w = int'(data[5:0]);
      REG_FRAME_HEIGHT:  frame_h = int'(data[5:0]);
      REG_CHANNEL_COUNT: plane_total = int'(data);
      default:           return;
    endcase
    next_col   = 0;
    next_row   = 0;
    next_plane = 0;
  endfunction

  // Store one pixel and queue the maxima of every window that it closes.
  function automatic void predict_pixel(input logic [VAL_W-1:0] px);
    int      w;
    int      h;
    int      cc;
    int      c;
    int      r;
    int      y0;
    int      x0;
    int      best;
    result_t res;
    result_t batch [$];
    w  = clamp_int(frame_w, 1, WIDTH_LIMIT);
    h  = clamp_int(frame_h, 1, HEIGHT_LIMIT);
    cc = clamp_int(plane_total, 1, PLANE_LIMIT);
    c  = (next_col >= w) ? w - 1 : next_col;
    r  = (next_row >= h) ? h - 1 : next_row;
    line_buf[(r % POOL) * MAX_WIDTH + c] = px;

    for (int wy = 0; wy * STRIDE < h && wy * STRIDE <= r; wy++) begin
      y0 = wy * STRIDE;
      if (span_end(y0, h) != r) continue;
      for (int wx = 0; wx * STRIDE < w && wx * STRIDE <= c; wx++) begin
        x0 = wx * STRIDE;
        if (span_end(x0, w) != c) continue;
        // The maximum starts from zero, so negative windows give zero.
        best = 0;
        for (int y = y0; y <= r; y++) begin
          for (int x = x0; x <= c; x++) begin
            if (line_buf[(y % POOL) * MAX_WIDTH + x] > best)
              best = line_buf[(y % POOL) * MAX_WIDTH + x];
          end
        end
        if (batch.size() < WIN_N) begin
          res.value = RES_W'(best);
          res.col   = COORD_W'(wx);
          res.row   = COORD_W'(wy);
          res.chan  = PLANE_W'(next_plane);
          res.last  = 1'b0;
          batch.push_back(res);
        end
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) pooled_q.push_back(batch[i]);

    // Advance the raster position, wrapping rows and planes.
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) begin
        r = 0;
        next_plane++;
        if (next_plane >= cc) next_plane = 0;
      end
    end
    next_col   = c;
    next_row   = r;
    next_plane = next_plane & 8'hFF;
  endfunction

  // Mostly full-range values, with a share of all-negative ones to hit the zero floor.
  function automatic logic [VAL_W-1:0] rand_pixel();
    if ($urandom_range(0, 3) == 0) return VAL_W'($urandom_range(16'h8000, 16'hFFFF));
    return VAL_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // Send one pixel; the sender works in bursts with random gaps between them.
  task automatic send_pixel(input logic [VAL_W-1:0] px);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    predict_pixel(px);
    pixels_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Stop sending until every pending result has arrived and the block has settled.
  task automatic wait_drained();
    hold_input();
    while (pooled_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    apply_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Width and height carry random bits above their six used bits.
  task automatic set_frame(input int w, input int h, input int ch);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, {3'($urandom), 6'(w)});
    write_reg(REG_FRAME_HEIGHT, {3'($urandom), 6'(h)});
    write_reg(REG_CHANNEL_COUNT, 9'(ch));
  endtask

  // Result checker: each result transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got = {out_tlast, out_tdata[RES_W + 2 * COORD_W + PLANE_W - 1:0]};
      if (pooled_q.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("%0t: unexpected result value %h col %0d row %0d chan %0d last %b",
                   $time, got.value, got.col, got.row, got.chan, got.last);
        error_count++;
      end else begin
        want = pooled_q.pop_front();
        if (got !== want || out_tdata[OUT_DATA_W-1 -: OUT_PAD_W] !== '0) begin
          if (error_count < MAX_REPORTS) begin
            $display("%0t: mismatch, expected value %h col %0d row %0d chan %0d last %b",
                     $time, want.value, want.col, want.row, want.chan, want.last);
            $display("  got value %h col %0d row %0d chan %0d last %b pad %h",
                     got.value, got.col, got.row, got.chan, got.last,
                     out_tdata[OUT_DATA_W-1 -: OUT_PAD_W]);
          end
          error_count++;
        end
      end
    end
  end

  // Receiver: switches between steady, choppy and starved stretches.
  initial begin
    out_tready = 1'b0;
    rx_mode    = RX_STEADY;
    rx_left    = 0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_left = $urandom_range(10, 120);
      end
      rx_left--;
      case (rx_mode)
        RX_STEADY:  out_tready <= 1'b1;
        RX_CHOPPY:  out_tready <= ($urandom_range(0, 3) != 0);
        RX_STARVED: out_tready <= ($urandom_range(0, 5) == 0);
        default:    out_tready <= 1'b1;
      endcase
    end
  end

  // Reset geometry of 24 x 24 x 64, with a full pause half way through.
  task automatic test_reset_geometry();
    for (int i = 0; i < 60; i++) begin
      if (i == 30) wait_drained();
      send_pixel(rand_pixel());
    end
  endtask

  // Extreme values: the largest positive wins, and an all-negative window gives zero.
  task automatic test_value_extremes();
    set_frame(2, 2, 2);
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);
    send_pixel(16'h0001);
    send_pixel(16'hFFFF);
    send_pixel(16'h8000);
    send_pixel(16'hFFFF);
    send_pixel(16'h8001);
    send_pixel(16'hFF00);
  endtask

  // Odd frame size gives windows cut at the right and bottom edges; a write to
  // the spare index mid-frame must not restart the frame.
  task automatic test_edge_windows();
    set_frame(3, 3, 1);
    send_pixel(rand_pixel());
    send_pixel(rand_pixel());
    wait_drained();
    write_reg(REG_SPARE, 9'($urandom));
    for (int i = 0; i < 7; i++) send_pixel(rand_pixel());
  endtask

  // Zero in every register is used as one.
  task automatic test_register_clamps();
    set_frame(0, 0, 0);
    send_pixel(16'h1234);
    send_pixel(16'hC000);
    send_pixel(16'h7FFF);
  endtask

  // Widest and tallest frames first, then many small random geometries.
  task automatic test_random_frames();
    int w;
    int h;
    int ch;
    int n;
    int sent_here;
    set_frame(63, 1, 3);
    for (int i = 0; i < 40; i++) send_pixel(rand_pixel());
    set_frame(1, 63, 2);
    for (int i = 0; i < 34; i++) send_pixel(rand_pixel());
    set_frame(32, 1, 256);
    for (int i = 0; i < 20; i++) send_pixel(rand_pixel());
    sent_here = 0;
    while (sent_here < 64) begin
      w  = $urandom_range(1, 8);
      h  = $urandom_range(1, 8);
      ch = $urandom_range(1, 4);
      n  = $urandom_range(w * h / 2 + 1, w * h * ch + w);
      if (n > 50) n = 50;
      set_frame(w, h, ch);
      for (int i = 0; i < n; i++) begin
        if (i == n / 2 && $urandom_range(0, 2) == 0) wait_drained();
        send_pixel(rand_pixel());
      end
      sent_here += n;
    end
  endtask

  // One-pixel planes with twenty channels: the channel index wraps back to zero.
  task automatic test_plane_wrap();
    set_frame(1, 1, 20);
    for (int i = 0; i < 24; i++) send_pixel(rand_pixel());
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    error_count  = 0;
    pixels_sent  = 0;
    results_seen = 0;
    reg_writes   = 0;
    burst_left   = 0;
    frame_w      = int'(FRAME_WIDTH_RST);
    frame_h      = int'(FRAME_HEIGHT_RST);
    plane_total  = int'(CHANNEL_COUNT_RST);
    next_col     = 0;
    next_row     = 0;
    next_plane   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_geometry();
    test_value_extremes();
    test_edge_windows();
    test_register_clamps();
    test_random_frames();
    test_plane_wrap();

    wait_drained();
    $display("Sent %0d pixels over %0d register writes; checked %0d pooled results.",
             pixels_sent, reg_writes, results_seen);
    $display("Frames ranged from 1x1 to 32 wide and 32 tall, up to 256 channels.");
    if (error_count == 0 && pooled_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures, %0d results missing", error_count, pooled_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
